FILE: rtl/cro_pkg.sv
package cro_pkg;

  localparam int MAX_OPS   = 1024;
  localparam int CNT_W     = $clog2(MAX_OPS + 2);
  localparam int OP_IDX_W  = 11;
  localparam int LEN_W     = 28;
  localparam int OPC_W     = 4;

  // CIGAR opcodes; 9 is treated as M
  localparam logic [OPC_W-1:0] OP_M   = 4'd0;
  localparam logic [OPC_W-1:0] OP_I   = 4'd1;
  localparam logic [OPC_W-1:0] OP_D   = 4'd2;
  localparam logic [OPC_W-1:0] OP_N   = 4'd3;
  localparam logic [OPC_W-1:0] OP_S   = 4'd4;
  localparam logic [OPC_W-1:0] OP_H   = 4'd5;
  localparam logic [OPC_W-1:0] OP_P   = 4'd6;
  localparam logic [OPC_W-1:0] OP_EQ  = 4'd7;
  localparam logic [OPC_W-1:0] OP_X   = 4'd8;
  localparam logic [OPC_W-1:0] OP_ALT = 4'd9;

  typedef struct packed {
    logic [31:0] cigar_word;
    logic [31:0] ref_offset;
    logic        last_op;
  } cro_in_t;

  typedef struct packed {
    logic [31:0]         query_offset;
    logic                found;
    logic [OP_IDX_W-1:0] op_index;
    logic [LEN_W-1:0]    offset_in_op;
    logic [31:0]         total_query_len;
    logic [31:0]         total_ref_len;
  } cro_out_t;

  function automatic logic uses_query(input logic [OPC_W-1:0] op);
    logic q;
    case (op)
      OP_M, OP_I, OP_S, OP_EQ, OP_X, OP_ALT: q = 1'b1;
      default:                              q = 1'b0;
    endcase
    return q;
  endfunction

  function automatic logic uses_ref(input logic [OPC_W-1:0] op);
    logic r;
    case (op)
      OP_M, OP_D, OP_N, OP_EQ, OP_X, OP_ALT: r = 1'b1;
      default:                              r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

FILE: rtl/cigar_ref_to_query_offset.sv
// Maps a reference offset onto the query through a streamed alignment CIGAR,
// one packed word per transaction (opcode in bits 3:0, run length above it).
// The reference offset is taken from the first word of each record; the word
// flagged last_op closes the record and yields one result: query offset, hit
// flag, hit op index and position within it, and the saturating query and
// reference lengths. Other words give no result. The block accepts one word
// per clock while in_stall is low; each accepted word sits in the input
// register while the combinational state update (one 32-bit compare, one
// subtract and up to three saturating adds) computes the value loaded into
// the result register when the word advances.
// A waiting result stalls the input only when the next word also closes a
// record. Words beyond 1024 in a record are ignored, apart from closing it.
module cigar_ref_to_query_offset
  import cro_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  cro_in_t  in_data,
  output logic     in_stall,
  output logic     out_valid,
  output cro_out_t out_data,
  input  logic     out_stall
);

  logic     item_valid;
  cro_in_t  item;
  logic     out_free;
  logic     advance;
  cro_out_t result;

  assign advance = item_valid && (!item.last_op || out_free);

  cro_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  cro_map_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .result  (result)
  );

  cro_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && item.last_op),
    .result    (result),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

FILE: rtl/cro_in_stage.sv
module cro_in_stage
  import cro_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  cro_in_t in_data,
  output logic    in_stall,
  input  logic    advance,
  output logic    item_valid,
  output cro_in_t item
);

  logic    valid_r;
  cro_in_t data_r;

  // hold the registered transaction until the core takes it
  assign in_stall   = valid_r && !advance;
  assign item_valid = valid_r;
  assign item       = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      data_r <= in_data;
    end
  end

endmodule

FILE: rtl/cro_map_core.sv
module cro_map_core
  import cro_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     advance,
  input  cro_in_t  item,
  output cro_out_t result
);

  localparam logic [CNT_W-1:0] MAX_OPS_C = CNT_W'(MAX_OPS);

  logic             record_open_r, record_open_nxt;
  logic [31:0]      remaining_ref_r, remaining_ref_nxt;
  logic [31:0]      query_pos_r, query_pos_nxt;
  logic             hit_flag_r, hit_flag_nxt;
  logic [CNT_W-1:0] hit_index_r, hit_index_nxt;
  logic [LEN_W-1:0] hit_offset_r, hit_offset_nxt;
  logic [CNT_W-1:0] op_counter_r, op_counter_nxt;
  logic [31:0]      query_sum_r, query_sum_nxt;
  logic [31:0]      ref_sum_r, ref_sum_nxt;

  always_comb begin
    logic [OPC_W-1:0] op;
    logic [31:0]      len;
    logic             q;
    logic             r;
    logic [CNT_W-1:0] cnt_p1;

    op  = item.cigar_word[OPC_W-1:0];
    len = {4'd0, item.cigar_word[31:4]};
    q   = uses_query(op);
    r   = uses_ref(op);

    remaining_ref_nxt = remaining_ref_r;
    query_pos_nxt     = query_pos_r;
    hit_flag_nxt      = hit_flag_r;
    hit_index_nxt     = hit_index_r;
    hit_offset_nxt    = hit_offset_r;
    op_counter_nxt    = op_counter_r;
    query_sum_nxt     = query_sum_r;
    ref_sum_nxt       = ref_sum_r;

    // first word of a record: start from a clean slate
    if (!record_open_r) begin
      remaining_ref_nxt = item.ref_offset;
      query_pos_nxt     = '0;
      hit_flag_nxt      = 1'b0;
      hit_index_nxt     = '0;
      hit_offset_nxt    = '0;
      op_counter_nxt    = '0;
      query_sum_nxt     = '0;
      ref_sum_nxt       = '0;
    end

    // drop words beyond the op limit
    if (op_counter_nxt < MAX_OPS_C) begin
      if (!hit_flag_nxt) begin
        if (r && (len != '0) && (remaining_ref_nxt < len)) begin
          hit_flag_nxt   = 1'b1;
          hit_index_nxt  = op_counter_nxt;
          hit_offset_nxt = remaining_ref_nxt[LEN_W-1:0];
          if (q) begin
            query_pos_nxt = sat_add(query_pos_nxt, remaining_ref_nxt);
          end
        end else begin
          if (r) begin
            remaining_ref_nxt = remaining_ref_nxt - len;
          end
          if (q) begin
            query_pos_nxt = sat_add(query_pos_nxt, len);
          end
        end
      end
      if (q) begin
        query_sum_nxt = sat_add(query_sum_nxt, len);
      end
      if (r) begin
        ref_sum_nxt = sat_add(ref_sum_nxt, len);
      end
      op_counter_nxt = op_counter_nxt + 1'b1;
    end

    record_open_nxt = !item.last_op;

    cnt_p1                 = op_counter_nxt + 1'b1;
    result.query_offset    = query_pos_nxt;
    result.found           = hit_flag_nxt;
    result.op_index        = hit_flag_nxt ? OP_IDX_W'(hit_index_nxt) : OP_IDX_W'(cnt_p1);
    result.offset_in_op    = hit_flag_nxt ? hit_offset_nxt : '0;
    result.total_query_len = query_sum_nxt;
    result.total_ref_len   = ref_sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      record_open_r <= 1'b0;
    end else if (advance) begin
      record_open_r <= record_open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      remaining_ref_r <= remaining_ref_nxt;
      query_pos_r     <= query_pos_nxt;
      hit_flag_r      <= hit_flag_nxt;
      hit_index_r     <= hit_index_nxt;
      hit_offset_r    <= hit_offset_nxt;
      op_counter_r    <= op_counter_nxt;
      query_sum_r     <= query_sum_nxt;
      ref_sum_r       <= ref_sum_nxt;
    end
  end

endmodule

FILE: rtl/cro_out_stage.sv
module cro_out_stage
  import cro_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,
  input  cro_out_t result,
  output logic     out_free,
  output logic     out_valid,
  output cro_out_t out_data,
  input  logic     out_stall
);

  logic     valid_r;
  cro_out_t data_r;

  assign out_free  = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

endmodule

FILE: rtl/cro_checker.sv
module cro_checker
  import cro_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_stall,
  input logic     out_valid,
  input cro_out_t out_data,
  input logic     out_stall
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // the input only backs up behind a stalled result
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |->
      out_data.offset_in_op == '0 && out_data.query_offset == out_data.total_query_len)
    else $error("miss result inconsistent");

  a_hit_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |->
      out_data.op_index < OP_IDX_W'(MAX_OPS) &&
      out_data.total_ref_len > {4'd0, out_data.offset_in_op} &&
      out_data.query_offset <= out_data.total_query_len)
    else $error("hit result out of bounds");

endmodule

bind cigar_ref_to_query_offset cro_checker u_chk (.*);
